FILE: sv/afp_pkg.sv
// Package for the API frame parser: request and result structs, phase type,
// header sizes, result kinds and register indexes.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package afp_pkg;

    // Frame delimiter byte.
    localparam logic [7:0] FRAME_DELIM = 8'h7E;

    // Header layouts as held during a frame.
    localparam logic [1:0] LAYOUT_RX     = 2'd0;
    localparam logic [1:0] LAYOUT_LOCAL  = 2'd1;
    localparam logic [1:0] LAYOUT_REMOTE = 2'd2;
    localparam logic [1:0] LAYOUT_UNUSED = 2'd3;

    // Header sizes in bytes for each layout.
    localparam logic [3:0] HDR_RX     = 4'd12;
    localparam logic [3:0] HDR_LOCAL  = 4'd5;
    localparam logic [3:0] HDR_REMOTE = 4'd15;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;

    // Request kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes and port sizes.
    localparam int  CFG_ADDR_W    = 3;
    localparam int  CFG_DATA_W    = 32;
    localparam logic REG_LAYOUT   = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LENHI = 3'd1,
        PH_LENLO = 3'd2,
        PH_HEAD  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } phase_t;

    // One input request.
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [7:0]  api_id;
        logic [63:0] long_address;
        logic [15:0] short_address;
        logic [7:0]  frame_ident;
        logic [15:0] at_command;
        logic [7:0]  status_or_options;
        logic [15:0] payload_length;
        logic [7:0]  checksum_byte;
    } result_t;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic [1:0]  frame_layout;
        logic [15:0] timeout_ticks;
    } cfg_t;

    // A result handed from the parser to the output register.
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_req_t;

    // Header size of a held layout.
    function automatic logic [3:0] hdr_size(input logic [1:0] layout);
        logic [3:0] size;
        unique case (layout)
            LAYOUT_LOCAL:  size = HDR_LOCAL;
            LAYOUT_REMOTE: size = HDR_REMOTE;
            default:       size = HDR_RX;
        endcase
        return size;
    endfunction

endpackage

FILE: sv/afp_cfg_regs.sv
// Configuration registers of the API frame parser behind an APB-style port.
// Depends on afp_pkg for register indexes, widths and the cfg_t struct.
`timescale 1ns / 1ps

module afp_cfg_regs
    import afp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [1:0]  layout_reg;
    logic [15:0] timeout_reg;
    logic        wr_en;
    logic        reg_sel;

    // Registers sit at byte addresses 0 and 4.
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg  <= LAYOUT_RX;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LAYOUT:  layout_reg  <= pwdata[1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                default:     layout_reg  <= layout_reg;
            endcase
        end
    end

    // Read back of the selected register.
    always_comb
    begin
        unique case (reg_sel)
            REG_LAYOUT:  prdata = {{(CFG_DATA_W-2){1'b0}}, layout_reg};
            REG_TIMEOUT: prdata = {{(CFG_DATA_W-16){1'b0}}, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.frame_layout  = layout_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

FILE: sv/afp_parser.sv
// Frame parser core: phase register, counters and held header fields, updated
// once per accepted request. Depends on afp_pkg for types and constants.
`timescale 1ns / 1ps

module afp_parser
    import afp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  cfg_t        cfg,
    output result_req_t res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] field_count_reg, field_count_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [1:0]  layout_reg, layout_next;
    logic [7:0]  api_id_reg, api_id_next;
    logic [63:0] long_addr_reg, long_addr_next;
    logic [15:0] short_addr_reg, short_addr_next;
    logic [7:0]  frame_ident_reg, frame_ident_next;
    logic [15:0] command_reg, command_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] idle_reg, idle_next;

    logic        is_tick;
    logic [7:0]  b;
    logic [15:0] hdr16;
    logic [15:0] payload_len;
    logic [15:0] fc_inc;
    logic        hdr_done;
    logic        data_last;
    logic        timed_out;
    logic [3:0]  hidx;
    result_t     summary;

    assign is_tick = (item.func == FUNC_TICK);
    assign b       = item.rx_byte;

    // Header size, payload length (floored at zero) and counter compares.
    assign hdr16       = {12'd0, hdr_size(layout_reg)};
    assign payload_len = (frame_length_reg > hdr16) ? (frame_length_reg - hdr16) : 16'd0;
    assign fc_inc      = field_count_reg + 16'd1;
    assign hdr_done    = (fc_inc >= hdr16);
    assign data_last   = (fc_inc >= payload_len);
    assign timed_out   = (idle_reg == cfg.timeout_ticks);
    assign hidx        = field_count_reg[3:0];

    // Held header fields as they stand, shared by every result.
    always_comb
    begin
        summary                   = '0;
        summary.api_id            = api_id_reg;
        summary.long_address      = long_addr_reg;
        summary.short_address     = short_addr_reg;
        summary.frame_ident       = frame_ident_reg;
        summary.at_command        = command_reg;
        summary.status_or_options = status_reg;
        summary.payload_length    = payload_len;
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (is_tick)
            begin
                if (phase_reg != PH_HUNT && timed_out)
                begin
                    phase_next = PH_HUNT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:  phase_next = (b == FRAME_DELIM) ? PH_LENHI : PH_HUNT;
                    PH_LENHI: phase_next = PH_LENLO;
                    PH_LENLO: phase_next = ({frame_length_reg[15:8], b} == 16'd0) ?
                                           PH_HUNT : PH_HEAD;
                    PH_HEAD:
                    begin
                        if (hdr_done)
                        begin
                            phase_next = (payload_len == 16'd0) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA:  phase_next = data_last ? PH_CSUM : PH_DATA;
                    PH_CSUM:  phase_next = PH_HUNT;
                    default:  phase_next = PH_HUNT;
                endcase
            end
        end
    end

    // Counters, held fields and the result of this request.
    always_comb
    begin
        field_count_next  = field_count_reg;
        frame_length_next = frame_length_reg;
        layout_next       = layout_reg;
        api_id_next       = api_id_reg;
        long_addr_next    = long_addr_reg;
        short_addr_next   = short_addr_reg;
        frame_ident_next  = frame_ident_reg;
        command_next      = command_reg;
        status_next       = status_reg;
        idle_next         = idle_reg;
        res.valid         = 1'b0;
        res.data          = summary;

        if (fire)
        begin
            if (is_tick)
            begin
                // Ticks count idle time inside a frame only.
                if (phase_reg != PH_HUNT)
                begin
                    if (timed_out)
                    begin
                        res.valid        = 1'b1;
                        res.data.kind    = KIND_ABORT;
                        idle_next        = 16'd0;
                        field_count_next = 16'd0;
                    end
                    else
                    begin
                        idle_next = idle_reg + 16'd1;
                    end
                end
            end
            else
            begin
                idle_next = 16'd0;
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        // A delimiter starts a frame and latches the layout.
                        if (b == FRAME_DELIM)
                        begin
                            api_id_next       = 8'd0;
                            long_addr_next    = 64'd0;
                            short_addr_next   = 16'd0;
                            frame_ident_next  = 8'd0;
                            command_next      = 16'd0;
                            status_next       = 8'd0;
                            frame_length_next = 16'd0;
                            field_count_next  = 16'd0;
                            layout_next       = (cfg.frame_layout == LAYOUT_UNUSED) ?
                                                LAYOUT_RX : cfg.frame_layout;
                        end
                    end
                    PH_LENHI:
                    begin
                        frame_length_next = {b, 8'd0};
                    end
                    PH_LENLO:
                    begin
                        frame_length_next = {frame_length_reg[15:8], b};
                        field_count_next  = 16'd0;
                        // An empty frame completes at once.
                        if ({frame_length_reg[15:8], b} == 16'd0)
                        begin
                            res.valid               = 1'b1;
                            res.data.kind           = KIND_COMPLETE;
                            res.data.payload_length = 16'd0;
                        end
                    end
                    PH_HEAD:
                    begin
                        field_count_next = hdr_done ? 16'd0 : fc_inc;
                        // Route the header byte by its place in the layout.
                        if (hidx == 4'd0)
                        begin
                            api_id_next = b;
                        end
                        else if (layout_reg == LAYOUT_LOCAL)
                        begin
                            if (hidx == 4'd1)
                                frame_ident_next = b;
                            else if (hidx <= 4'd3)
                                command_next = {command_reg[7:0], b};
                            else
                                status_next = b;
                        end
                        else if (layout_reg == LAYOUT_REMOTE)
                        begin
                            if (hidx == 4'd1)
                                frame_ident_next = b;
                            else if (hidx <= 4'd9)
                                long_addr_next = {long_addr_reg[55:0], b};
                            else if (hidx <= 4'd11)
                                short_addr_next = {short_addr_reg[7:0], b};
                            else if (hidx <= 4'd13)
                                command_next = {command_reg[7:0], b};
                            else
                                status_next = b;
                        end
                        else
                        begin
                            if (hidx <= 4'd8)
                                long_addr_next = {long_addr_reg[55:0], b};
                            else if (hidx <= 4'd10)
                                short_addr_next = {short_addr_reg[7:0], b};
                            else
                                status_next = b;
                        end
                    end
                    PH_DATA:
                    begin
                        res.valid             = 1'b1;
                        res.data.kind         = KIND_PAYLOAD;
                        res.data.payload_byte = b;
                        res.data.last_payload = data_last;
                        field_count_next      = data_last ? 16'd0 : fc_inc;
                    end
                    PH_CSUM:
                    begin
                        res.valid              = 1'b1;
                        res.data.kind          = KIND_COMPLETE;
                        res.data.checksum_byte = b;
                        field_count_next       = 16'd0;
                    end
                    default:
                    begin
                        field_count_next = field_count_reg;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            field_count_reg  <= 16'd0;
            frame_length_reg <= 16'd0;
            layout_reg       <= LAYOUT_RX;
            api_id_reg       <= 8'd0;
            long_addr_reg    <= 64'd0;
            short_addr_reg   <= 16'd0;
            frame_ident_reg  <= 8'd0;
            command_reg      <= 16'd0;
            status_reg       <= 8'd0;
            idle_reg         <= 16'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            field_count_reg  <= field_count_next;
            frame_length_reg <= frame_length_next;
            layout_reg       <= layout_next;
            api_id_reg       <= api_id_next;
            long_addr_reg    <= long_addr_next;
            short_addr_reg   <= short_addr_next;
            frame_ident_reg  <= frame_ident_next;
            command_reg      <= command_next;
            status_reg       <= status_next;
            idle_reg         <= idle_next;
        end
    end

endmodule

FILE: sv/afp_out_reg.sv
// Result register of the API frame parser with valid/ready handshake.
// Depends on afp_pkg for result_t and result_req_t.
`timescale 1ns / 1ps

module afp_out_reg
    import afp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  result_req_t res,
    output logic        free,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The register can take a new result when empty or being drained.
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = res.valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result data loads only with a new result.
    always_ff @(posedge clk)
    begin
        if (free && res.valid)
        begin
            data_reg <= res.data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

FILE: sv/api_frame_parser.sv
// Top level of the API frame parser: configuration port, parser core and
// result register. Depends on afp_pkg, afp_cfg_regs, afp_parser, afp_out_reg.
`timescale 1ns / 1ps
//
// Usage
//   Requests arrive on item/item_valid/item_ready: a received serial byte
//   (func 0) or one time tick (func 1). The parser hunts for the 0x7E
//   delimiter, reads a big-endian length and the header chosen by
//   frame_layout, then returns each payload byte as a result, followed by a
//   frame summary carrying the received checksum. A frame left idle for more
//   than timeout_ticks ticks is aborted with a result of its own.
//   Results leave on result/result_valid/result_ready, at most one per request.
//   Results are registered: a result is valid in the cycle after the request
//   that makes it. One request is accepted per cycle while the result register
//   has room; the phase and counter update of the parser core completes in the
//   cycle of acceptance. While the receiver stalls with a result pending,
//   item_ready is low and requests wait; when the result is taken, a new request
//   is accepted in the same cycle. Reset returns the parser to delimiter hunting,
//   empties the result register and loads layout 0 and a timeout of 1000 ticks.
//   The user writes the registers over the APB-style port only while the block
//   idles; the block itself does not enforce this.

module api_frame_parser
    import afp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t        cfg;
    result_req_t res;
    logic        free;
    logic        fire;

    // A request is taken whenever the result register has room.
    assign item_ready = free;
    assign fire       = item_valid && free;

    afp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    afp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .free         (free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: verif/afp_checker.sv
// Checker for the API frame parser: watches the request, result and register
// channels, predicts each result and compares it field by field.
// Depends on afp_pkg for the request, result and phase types and constants.
`timescale 1ns / 1ps

module afp_checker
    import afp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    // Register copies.
    logic [1:0]  layout_reg;
    logic [15:0] tick_limit;

    // Parser state as this checker tracks it.
    phase_t      fsm_phase;
    logic [1:0]  frame_shape;
    logic [15:0] byte_count;
    logic [15:0] frame_len;
    logic [15:0] idle_count;
    logic [7:0]  api_id_q;
    logic [63:0] long_addr_q;
    logic [15:0] short_addr_q;
    logic [7:0]  ident_q;
    logic [15:0] command_q;
    logic [7:0]  status_q;

    result_t     pending_results[$];
    int          err_count;

    function automatic logic [15:0] header_bytes(input logic [1:0] shape);
        case (shape)
            LAYOUT_LOCAL:  return 16'(HDR_LOCAL);
            LAYOUT_REMOTE: return 16'(HDR_REMOTE);
            default:       return 16'(HDR_RX);
        endcase
    endfunction

    // Payload size is the length less the header, never below zero.
    function automatic logic [15:0] payload_count();
        logic [15:0] hdr;
        hdr = header_bytes(frame_shape);
        return (frame_len > hdr) ? frame_len - hdr : 16'd0;
    endfunction

    // A result carrying the header fields held so far.
    function automatic result_t frame_report(input logic [1:0] kind);
        result_t r;
        r                   = '0;
        r.kind              = kind;
        r.api_id            = api_id_q;
        r.long_address      = long_addr_q;
        r.short_address     = short_addr_q;
        r.frame_ident       = ident_q;
        r.at_command        = command_q;
        r.status_or_options = status_q;
        r.payload_length    = payload_count();
        return r;
    endfunction

    // Header bytes land in fields that depend on the latched layout.
    task automatic take_header_byte(input logic [15:0] idx, input logic [7:0] b);
        if (idx == 0) begin
            api_id_q = b;
        end
        else begin
            case (frame_shape)
                LAYOUT_LOCAL:
                begin
                    if (idx == 1)      ident_q   = b;
                    else if (idx <= 3) command_q = {command_q[7:0], b};
                    else               status_q  = b;
                end
                LAYOUT_REMOTE:
                begin
                    if (idx == 1)       ident_q      = b;
                    else if (idx <= 9)  long_addr_q  = {long_addr_q[55:0], b};
                    else if (idx <= 11) short_addr_q = {short_addr_q[7:0], b};
                    else if (idx <= 13) command_q    = {command_q[7:0], b};
                    else                status_q     = b;
                end
                default:
                begin
                    if (idx <= 8)       long_addr_q  = {long_addr_q[55:0], b};
                    else if (idx <= 10) short_addr_q = {short_addr_q[7:0], b};
                    else                status_q     = b;
                end
            endcase
        end
    endtask

    // Steps the parser by one request and queues the result it makes, if any.
    task automatic advance_parser(input item_t req);
        result_t r;
        if (req.func == FUNC_TICK) begin
            // Ticks only matter inside a frame.
            if (fsm_phase != PH_HUNT) begin
                if (idle_count == tick_limit) begin
                    pending_results.push_back(frame_report(KIND_ABORT));
                    fsm_phase  = PH_HUNT;
                    idle_count = '0;
                    byte_count = '0;
                end
                else begin
                    idle_count = idle_count + 16'd1;
                end
            end
        end
        else begin
            idle_count = '0;
            case (fsm_phase)
                PH_HUNT:
                begin
                    if (req.rx_byte == FRAME_DELIM) begin
                        api_id_q     = '0;
                        long_addr_q  = '0;
                        short_addr_q = '0;
                        ident_q      = '0;
                        command_q    = '0;
                        status_q     = '0;
                        frame_len    = '0;
                        byte_count   = '0;
                        frame_shape  = (layout_reg == LAYOUT_UNUSED) ? LAYOUT_RX : layout_reg;
                        fsm_phase    = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    frame_len = {req.rx_byte, 8'h00};
                    fsm_phase = PH_LENLO;
                end
                PH_LENLO:
                begin
                    frame_len[7:0] = req.rx_byte;
                    byte_count     = '0;
                    if (frame_len == 0) begin
                        pending_results.push_back(frame_report(KIND_COMPLETE));
                        fsm_phase = PH_HUNT;
                    end
                    else begin
                        fsm_phase = PH_HEAD;
                    end
                end
                PH_HEAD:
                begin
                    take_header_byte(byte_count, req.rx_byte);
                    byte_count = byte_count + 16'd1;
                    if (byte_count >= header_bytes(frame_shape)) begin
                        byte_count = '0;
                        fsm_phase  = (payload_count() == 0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    r              = frame_report(KIND_PAYLOAD);
                    r.payload_byte = req.rx_byte;
                    byte_count     = byte_count + 16'd1;
                    if (byte_count >= payload_count()) begin
                        r.last_payload = 1'b1;
                        byte_count     = '0;
                        fsm_phase      = PH_CSUM;
                    end
                    pending_results.push_back(r);
                end
                PH_CSUM:
                begin
                    r               = frame_report(KIND_COMPLETE);
                    r.checksum_byte = req.rx_byte;
                    pending_results.push_back(r);
                    fsm_phase  = PH_HUNT;
                    byte_count = '0;
                end
                default:
                begin
                    fsm_phase = PH_HUNT;
                end
            endcase
        end
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Each result taken is matched against the oldest prediction.
    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind 0x%0h", got.kind);
            err_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("payload_byte", want.payload_byte, got.payload_byte);
        compare_field("last_payload", want.last_payload, got.last_payload);
        compare_field("api_id", want.api_id, got.api_id);
        compare_field("long_address", want.long_address, got.long_address);
        compare_field("short_address", want.short_address, got.short_address);
        compare_field("frame_ident", want.frame_ident, got.frame_ident);
        compare_field("at_command", want.at_command, got.at_command);
        compare_field("status_or_options", want.status_or_options, got.status_or_options);
        compare_field("payload_length", want.payload_length, got.payload_length);
        compare_field("checksum_byte", want.checksum_byte, got.checksum_byte);
    endtask

    // Register writes, result checks and request predictions, in that order.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            layout_reg   = LAYOUT_RX;
            tick_limit   = TIMEOUT_RESET;
            fsm_phase    = PH_HUNT;
            frame_shape  = LAYOUT_RX;
            byte_count   = '0;
            frame_len    = '0;
            idle_count   = '0;
            api_id_q     = '0;
            long_addr_q  = '0;
            short_addr_q = '0;
            ident_q      = '0;
            command_q    = '0;
            status_q     = '0;
            err_count    = 0;
            pending_results.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[CFG_ADDR_W-1:2] == REG_LAYOUT)
                    layout_reg = pwdata[1:0];
                else if (paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT)
                    tick_limit = pwdata[15:0];
            end
            if (result_valid && result_ready)
                check_result(result);
            if (item_valid && item_ready)
                advance_parser(item);
            outstanding <= pending_results.size();
            mismatches  <= err_count;
        end
    end

endmodule

FILE: verif/api_frame_parser_test.sv
// Top of the API frame parser testbench: clock, reset, request and register
// stimulus, receiver stalls, watchdog and verdict.
// Depends on afp_pkg, api_frame_parser and afp_checker.
`timescale 1ns / 1ps

module api_frame_parser_test;
    import afp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int          failures;
    int          outstanding;
    int          stall_cycles = 0;
    int          frame_bytes  = 0;
    logic [1:0]  cur_layout   = LAYOUT_RX;
    logic [15:0] cur_timeout  = TIMEOUT_RESET;
    bit          send_gaps    = 1'b1;
    bit          recv_gaps    = 1'b1;
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;

    always #1 clk = ~clk;

    api_frame_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    afp_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (failures),
        .outstanding  (outstanding)
    );

    // Watchdog: ends the run after too long without any handshake.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold when asked for.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (recv_gaps && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offers one request and waits until it is accepted.
    task automatic send_item(input logic f, input logic [7:0] b);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item       <= {f, b};
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Stops offering and lets every expected result drain out.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access cycles of one register write; psel stays high after.
    task automatic apb_access(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] shape, input logic [15:0] ticks);
        apb_access(CFG_ADDR_W'(4 * REG_LAYOUT), CFG_DATA_W'(shape));
        apb_access(CFG_ADDR_W'(4 * REG_TIMEOUT), CFG_DATA_W'(ticks));
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        cur_layout  = shape;
        cur_timeout = ticks;
    endtask

    function automatic logic [7:0] frame_content();
        return ($urandom_range(0, 19) == 0) ? FRAME_DELIM : 8'($urandom);
    endfunction

    // One frame for the current layout, its length at times short of the header,
    // sometimes cut short and left to time out. Spare ticks between bytes never exceed the timeout.
    task automatic send_frame();
        logic [15:0] hdr;
        logic [15:0] len;
        logic [7:0]  frame[$];
        int          pick;
        int          cut;
        int          body;
        hdr  = (cur_layout == LAYOUT_LOCAL)  ? 16'(HDR_LOCAL) :
               (cur_layout == LAYOUT_REMOTE) ? 16'(HDR_REMOTE) : 16'(HDR_RX);
        pick = $urandom_range(0, 15);
        if (pick == 0)      len = 16'd0;
        else if (pick <= 2) len = 16'($urandom_range(1, hdr - 1));
        else if (pick == 3) len = hdr;
        else                len = hdr + 16'($urandom_range(1, 16));
        frame = {FRAME_DELIM, len[15:8], len[7:0]};
        if (len != 0)
        begin
            body = hdr + ((len > hdr) ? len - hdr : 0) + 1;
            repeat (body) frame.push_back(frame_content());
        end
        cut = frame.size();
        if (cur_timeout <= 16 && $urandom_range(0, 5) == 0)
            cut = $urandom_range(1, frame.size() - 1);
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, (cur_timeout < 2) ? cur_timeout : 2))
                    send_item(FUNC_TICK, 8'($urandom));
            send_item(FUNC_BYTE, frame[i]);
            frame_bytes++;
        end
        if (cut < frame.size())
            repeat (cur_timeout + 1) send_item(FUNC_TICK, 8'($urandom));
    endtask

    // Mostly frames with random content, some noise in between.
    task automatic run_frames(input int target);
        int start;
        start = frame_bytes;
        while (frame_bytes - start < target)
        begin
            if (!steady && $urandom_range(0, 9) == 0)
            begin
                send_gaps = ($urandom_range(0, 2) != 0);
                recv_gaps = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(logic'($urandom_range(0, 1)), 8'($urandom));
            send_frame();
        end
    endtask

    initial
    begin
        item_t script[$];
        script = '{
            {FUNC_TICK, 8'hFF}, {FUNC_BYTE, 8'h00},
            {FUNC_BYTE, FRAME_DELIM}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'h00},
            {FUNC_BYTE, FRAME_DELIM}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'h0E},
            {FUNC_BYTE, FRAME_DELIM},
            {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF},
            {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF},
            {FUNC_TICK, 8'h00},
            {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'hFF},
            {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'hA5}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout and timeout: idle ticks, a zero-length frame, and a
        // receive packet with extreme header bytes and a delimiter as API id.
        foreach (script[i]) send_item(script[i].func, script[i].rx_byte);
        run_frames(100);

        // Layout is latched at the delimiter: change it in the middle of a frame.
        send_item(FUNC_BYTE, FRAME_DELIM);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, 8'h10);
        settle();
        configure(LAYOUT_LOCAL, 16'd0);
        repeat (17) send_item(FUNC_BYTE, frame_content());
        run_frames(200);

        // Largest length, aborted by the timeout part way through the payload.
        settle();
        configure(LAYOUT_REMOTE, 16'd3);
        send_item(FUNC_BYTE, FRAME_DELIM);
        send_item(FUNC_BYTE, 8'hFF);
        send_item(FUNC_BYTE, 8'hFF);
        repeat (20) send_item(FUNC_BYTE, frame_content());
        repeat (4) send_item(FUNC_TICK, 8'($urandom));
        run_frames(200);

        // Unused layout code with the longest timeout: a long idle stretch
        // inside a frame stays far below it, and the frame then completes.
        settle();
        configure(LAYOUT_UNUSED, 16'hFFFF);
        run_frames(150);
        send_item(FUNC_BYTE, FRAME_DELIM);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, 8'h20);
        repeat (60) send_item(FUNC_TICK, 8'($urandom));
        repeat (33) send_item(FUNC_BYTE, frame_content());

        // Receiver holds off for a long stretch so the block stalls its input.
        settle();
        configure(LAYOUT_RX, 16'd5);
        hold_request = 1'b1;
        run_frames(230);

        // Closing stretch with no idling on either side.
        settle();
        configure(LAYOUT_LOCAL, 16'($urandom_range(1, 16)));
        steady    = 1'b1;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        run_frames(190);

        settle();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
sv/afp_pkg.sv
sv/afp_cfg_regs.sv
sv/afp_parser.sv
sv/afp_out_reg.sv
sv/api_frame_parser.sv
verif/afp_checker.sv
verif/api_frame_parser_test.sv
